### hw/rtl/asg_pkg.sv
// Shared types and constants for the multiformat audio sample gain block.
`timescale 1ns / 1ps

package asg_pkg;

    // Fractional bits of the linear gain
    localparam int GAIN_FRAC_BITS = 16;
    localparam int GAIN_W         = 18;
    localparam int SAMPLE_W       = 16;
    localparam int CFG_INDEX_W    = 8;
    localparam int CFG_DATA_W     = 18;

    // Pipeline depth from input register to output register
    localparam int PIPE_DEPTH     = 6;
    localparam int INFLIGHT_W     = $clog2(PIPE_DEPTH + 1);

    // Operand, product, offset-sum and scaled-numerator widths
    localparam int OPND_W  = SAMPLE_W + 1;
    localparam int PROD_W  = OPND_W + GAIN_W + 1;
    localparam int MID_W   = SAMPLE_W + GAIN_FRAC_BITS + 1;
    localparam int SUM_W   = ((PROD_W > MID_W) ? PROD_W : MID_W) + 1;
    localparam int NUM_W   = SUM_W + SAMPLE_W + 1;
    localparam int QUO_W   = SAMPLE_W + 1;

    // Gain after reset: unity, cut to the register width
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(64'd1 << GAIN_FRAC_BITS);

    // Sample formats
    typedef enum logic [1:0] {
        FMT_OFS8  = 2'd0,
        FMT_OFS16 = 2'd1,
        FMT_TC8   = 2'd2,
        FMT_TC16  = 2'd3
    } fmt_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FORMAT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN   = CFG_INDEX_W'(1);

endpackage

### hw/rtl/audio_sample_gain_multiformat.sv
// Top level of the multiformat audio sample gain pipeline.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  s_      | in        | s_valid / s_ready    | s_in_sample[15:0], s_in_last
//  m_      | out       | m_valid / m_ready    | m_out_sample[15:0], m_clipped, m_out_last
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index[7:0], cfg_data[17:0]
//
// One item per cycle sustained while m_ready is held high. A result is offered
// once its item has passed the six register stages (operand, multiply, offset
// add, scale, magnitude and shift, clamp).
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up and a stalled output still lets new items enter the empty stages.
// Synchronous active-low reset clears the valid bits and sets the two registers to FMT_OFS8 and unity gain.
// cfg_ready is always high; a write is taken in the cycle it is offered.
`timescale 1ns / 1ps

module audio_sample_gain_multiformat (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [asg_pkg::SAMPLE_W-1:0]     s_in_sample,
    input  logic                             s_in_last,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [asg_pkg::SAMPLE_W-1:0]     m_out_sample,
    output logic                             m_clipped,
    output logic                             m_out_last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [asg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [asg_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import asg_pkg::*;

    // Configuration registers
    fmt_t              format_reg;
    logic [GAIN_W-1:0] gain_reg;

    // Stage enables
    logic en1, en2, en3, en4, en5, en6;

    // Stage 1: signed operand
    logic                     v1_reg;
    fmt_t                     fmt1_reg;
    logic                     last1_reg;
    logic signed [OPND_W-1:0] opnd1_reg;
    logic signed [OPND_W-1:0] opnd1_next;

    // Stage 2: product with gain
    logic                     v2_reg;
    fmt_t                     fmt2_reg;
    logic                     last2_reg;
    logic signed [PROD_W-1:0] prod2_reg;

    // Stage 3: midpoint added back for offset formats
    logic                     v3_reg;
    fmt_t                     fmt3_reg;
    logic                     last3_reg;
    logic signed [SUM_W-1:0]  sum3_reg;
    logic signed [SUM_W-1:0]  sum3_next;

    // Stage 4: times 255 or 65535 for offset formats
    logic                     v4_reg;
    fmt_t                     fmt4_reg;
    logic                     last4_reg;
    logic signed [NUM_W-1:0]  num4_reg;
    logic signed [NUM_W-1:0]  num4_next;
    logic signed [NUM_W-1:0]  sum3_ext;

    // Stage 5: magnitude, shift, range flag
    logic                     v5_reg;
    fmt_t                     fmt5_reg;
    logic                     last5_reg;
    logic                     neg5_reg;
    logic                     big5_reg;
    logic [QUO_W-1:0]         quo5_reg;
    logic [NUM_W-1:0]         mag5;
    logic [NUM_W-1:0]         shf5;

    // Stage 6: clamp and pack
    logic                     m_valid_reg;
    logic [SAMPLE_W-1:0]      m_sample_reg;
    logic [SAMPLE_W-1:0]      m_sample_next;
    logic                     m_clip_reg;
    logic                     m_clip_next;
    logic                     m_last_reg;
    logic [QUO_W-1:0]         neg_quo;

    // Chain the enables back from the output register
    assign en6     = !m_valid_reg || m_ready;
    assign en5     = !v5_reg || en6;
    assign en4     = !v4_reg || en5;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    assign cfg_ready = 1'b1;

    // Write the configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg <= FMT_OFS8;
            gain_reg   <= GAIN_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_FORMAT) begin
                format_reg <= fmt_t'(cfg_data[1:0]);
            end else if (cfg_index == REG_GAIN) begin
                gain_reg <= cfg_data[GAIN_W-1:0];
            end
        end
    end

    // Center offset samples, sign-extend two's complement samples
    always_comb begin
        case (format_reg)
            FMT_OFS8:  opnd1_next = $signed({9'd0, s_in_sample[7:0]}) - OPND_W'(128);
            FMT_OFS16: opnd1_next = $signed({1'b0, s_in_sample}) - OPND_W'(32768);
            FMT_TC8:   opnd1_next = OPND_W'($signed(s_in_sample[7:0]));
            default:   opnd1_next = OPND_W'($signed(s_in_sample));
        endcase
    end

    // Add the scaled midpoint back for offset formats
    always_comb begin
        case (fmt2_reg)
            FMT_OFS8:  sum3_next = SUM_W'(prod2_reg) + (SUM_W'(128) <<< GAIN_FRAC_BITS);
            FMT_OFS16: sum3_next = SUM_W'(prod2_reg) + (SUM_W'(32768) <<< GAIN_FRAC_BITS);
            default:   sum3_next = SUM_W'(prod2_reg);
        endcase
    end

    // Scale by 255 or 65535 as a shift and subtract
    assign sum3_ext = NUM_W'(sum3_reg);
    always_comb begin
        case (fmt3_reg)
            FMT_OFS8:  num4_next = (sum3_ext <<< 8) - sum3_ext;
            FMT_OFS16: num4_next = (sum3_ext <<< 16) - sum3_ext;
            default:   num4_next = sum3_ext;
        endcase
    end

    // Truncate toward zero: shift the magnitude
    assign mag5 = num4_reg[NUM_W-1] ? NUM_W'(-num4_reg) : NUM_W'(num4_reg);
    always_comb begin
        case (fmt4_reg)
            FMT_OFS8:  shf5 = mag5 >> (GAIN_FRAC_BITS + 8);
            FMT_OFS16: shf5 = mag5 >> (GAIN_FRAC_BITS + 16);
            default:   shf5 = mag5 >> GAIN_FRAC_BITS;
        endcase
    end

    // Saturate to the format range and pack the raw bits
    assign neg_quo = QUO_W'(-quo5_reg);
    always_comb begin
        m_sample_next = '0;
        m_clip_next   = 1'b0;
        case (fmt5_reg)
            FMT_OFS8: begin
                if (neg5_reg) begin
                    m_clip_next = big5_reg || (quo5_reg != '0);
                end else if (big5_reg || quo5_reg > QUO_W'(255)) begin
                    m_sample_next = SAMPLE_W'(255);
                    m_clip_next   = 1'b1;
                end else begin
                    m_sample_next = {8'd0, quo5_reg[7:0]};
                end
            end
            FMT_OFS16: begin
                if (neg5_reg) begin
                    m_clip_next = big5_reg || (quo5_reg != '0);
                end else if (big5_reg || quo5_reg > QUO_W'(65535)) begin
                    m_sample_next = SAMPLE_W'(65535);
                    m_clip_next   = 1'b1;
                end else begin
                    m_sample_next = quo5_reg[SAMPLE_W-1:0];
                end
            end
            FMT_TC8: begin
                if (neg5_reg) begin
                    if (big5_reg || quo5_reg > QUO_W'(128)) begin
                        m_sample_next = SAMPLE_W'(8'h80);
                        m_clip_next   = 1'b1;
                    end else begin
                        m_sample_next = {8'd0, neg_quo[7:0]};
                    end
                end else if (big5_reg || quo5_reg > QUO_W'(127)) begin
                    m_sample_next = SAMPLE_W'(8'h7F);
                    m_clip_next   = 1'b1;
                end else begin
                    m_sample_next = {8'd0, quo5_reg[7:0]};
                end
            end
            default: begin
                if (neg5_reg) begin
                    if (big5_reg || quo5_reg > QUO_W'(32768)) begin
                        m_sample_next = SAMPLE_W'(16'h8000);
                        m_clip_next   = 1'b1;
                    end else begin
                        m_sample_next = neg_quo[SAMPLE_W-1:0];
                    end
                end else if (big5_reg || quo5_reg > QUO_W'(32767)) begin
                    m_sample_next = SAMPLE_W'(16'h7FFF);
                    m_clip_next   = 1'b1;
                end else begin
                    m_sample_next = quo5_reg[SAMPLE_W-1:0];
                end
            end
        endcase
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) v1_reg      <= s_valid;
            if (en2) v2_reg      <= v1_reg;
            if (en3) v3_reg      <= v2_reg;
            if (en4) v4_reg      <= v3_reg;
            if (en5) v5_reg      <= v4_reg;
            if (en6) m_valid_reg <= v5_reg;
        end
    end

    // Advance payload; hold while stalled
    always_ff @(posedge aclk) begin
        if (en1) begin
            fmt1_reg  <= format_reg;
            last1_reg <= s_in_last;
            opnd1_reg <= opnd1_next;
        end
        if (en2) begin
            fmt2_reg  <= fmt1_reg;
            last2_reg <= last1_reg;
            prod2_reg <= PROD_W'(opnd1_reg) * PROD_W'($signed({1'b0, gain_reg}));
        end
        if (en3) begin
            fmt3_reg  <= fmt2_reg;
            last3_reg <= last2_reg;
            sum3_reg  <= sum3_next;
        end
        if (en4) begin
            fmt4_reg  <= fmt3_reg;
            last4_reg <= last3_reg;
            num4_reg  <= num4_next;
        end
        if (en5) begin
            fmt5_reg  <= fmt4_reg;
            last5_reg <= last4_reg;
            neg5_reg  <= num4_reg[NUM_W-1];
            big5_reg  <= |shf5[NUM_W-1:QUO_W];
            quo5_reg  <= shf5[QUO_W-1:0];
        end
        if (en6) begin
            m_sample_reg <= m_sample_next;
            m_clip_reg   <= m_clip_next;
            m_last_reg   <= last5_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_sample = m_sample_reg;
    assign m_clipped    = m_clip_reg;
    assign m_out_last   = m_last_reg;

endmodule

### hw/rtl/asg_checker.sv
// Port-level checker for the audio sample gain pipeline and its bind.
`timescale 1ns / 1ps

module asg_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [asg_pkg::SAMPLE_W-1:0] m_out_sample,
    input logic                         m_clipped,
    input logic                         m_out_last
);
    import asg_pkg::*;

    // Items accepted but not yet delivered
    logic [INFLIGHT_W-1:0] inflight_reg;
    logic [INFLIGHT_W-1:0] inflight_next;
    logic                  s_fire;
    logic                  m_fire;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    // Track the count of items in flight
    always_comb begin
        inflight_next = inflight_reg;
        if (s_fire && !m_fire) inflight_next = inflight_reg + INFLIGHT_W'(1);
        if (!s_fire && m_fire) inflight_next = inflight_reg - INFLIGHT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // A stalled result holds its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_sample)
                                && $stable(m_clipped) && $stable(m_out_last))
        else $error("stalled result changed");

    // Reset empties the output
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // No result without an earlier accepted item
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != '0)
        else $error("result without an accepted item");

    // Never more items in flight than pipeline stages
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= INFLIGHT_W'(PIPE_DEPTH))
        else $error("more items in flight than stages");

endmodule

bind audio_sample_gain_multiformat asg_checker u_asg_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_sample (m_out_sample),
    .m_clipped    (m_clipped),
    .m_out_last   (m_out_last)
);
